// ===== rtl/sfdc_pkg.sv =====
// sfdc_pkg: shared types, constants and the crc-8 step for the sensor frame deframer
// no dependencies; used by the core and the testbench
package sfdc_pkg;

  localparam int MAX_PAYLOAD = 48;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] HEAD_BYTE_RST  = 8'hAA;
  localparam logic [7:0] TAIL_BYTE_RST  = 8'h55;
  localparam logic [7:0] CRC_POLY_RST   = 8'h07;
  localparam logic [7:0] CRC_START_RST  = 8'h00;
  localparam logic       CRC_LSB_RST    = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAD_BYTE  = 3'd0,
    REG_TAIL_BYTE  = 3'd1,
    REG_CRC_POLY   = 3'd2,
    REG_CRC_START  = 3'd3,
    REG_CRC_LSB    = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_HEAD,
    PH_LENGTH,
    PH_SENSOR,
    PH_DATA,
    PH_CRC,
    PH_TAIL,
    PH_EMIT
  } phase_t;

  typedef struct packed {
    logic [7:0] head_byte;
    logic [7:0] tail_byte;
    logic [7:0] crc_poly;
    logic [7:0] crc_start;
    logic       crc_lsb_first;
  } cfg_t;

  // one byte through the crc-8, msb or lsb first
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly, input logic lsb_first);
    logic [7:0] c;
    logic [7:0] rpoly;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      rpoly[i] = poly[7-i];
    end
    for (int i = 0; i < 8; i++) begin
      if (lsb_first) begin
        c = c[0] ? ((c >> 1) ^ rpoly) : (c >> 1);
      end else begin
        c = c[7] ? ((c << 1) ^ poly) : (c << 1);
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/sfdc_in_if.sv =====
// sfdc_in_if: valid/ready channel carrying one received byte per transaction
// no dependencies
interface sfdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/sfdc_out_if.sv =====
// sfdc_out_if: valid/ready channel carrying one decoded frame result per transaction
// no dependencies
interface sfdc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_sensor;
  logic [5:0] frame_length;
  logic [5:0] byte_position;
  logic [7:0] payload_value;
  logic       has_payload;
  logic       last_of_frame;

  modport source (output valid, output frame_sensor, output frame_length,
                  output byte_position, output payload_value, output has_payload,
                  output last_of_frame, input ready);
  modport sink (input valid, input frame_sensor, input frame_length,
                input byte_position, input payload_value, input has_payload,
                input last_of_frame, output ready);
endinterface

// ===== rtl/sfdc_ram.sv =====
// sfdc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module sfdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sensor_frame_deframer_crc8_core.sv =====
// sensor_frame_deframer_crc8_core: finds head/length/id/payload/crc-8/tail frames
// depends on sfdc_pkg, sfdc_in_if, sfdc_out_if and sfdc_ram
//
//   channel   dir  handshake      carries
//   in_ch     in   valid/ready    rx_byte
//   out_ch    out  valid/ready    frame_sensor .. last_of_frame
//   cfg_*     in   cfg_we only    register index and data
//
// each received byte is taken while in_ch.ready is high; the crc-8 step is done in the same cycle
// after a good tail, the payload ram is read back one entry per cycle while out does not
// stall; the ram read is registered, and the input is held until the last entry is loaded into out
// a frame of length zero gives its notice straight from the tail byte
// synchronous active-low reset; the payload ram is not cleared
module sensor_frame_deframer_crc8_core #(
  parameter int MAX_PAYLOAD = sfdc_pkg::MAX_PAYLOAD
) (
  input  logic                             clk,
  input  logic                             rst_n,
  sfdc_in_if.sink                          in_ch,
  sfdc_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [sfdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfdc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CW = $clog2(MAX_PAYLOAD + 1);

  sfdc_pkg::phase_t phase_r, phase_nxt;
  sfdc_pkg::cfg_t   cfg_r, cfg_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [7:0]    sensor_r, sensor_nxt;
  logic [7:0]    crc_r, crc_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    o_sensor_r, o_sensor_nxt;
  logic [5:0]    o_len_r, o_len_nxt;
  logic [5:0]    o_pos_r, o_pos_nxt;
  logic [7:0]    o_val_r, o_val_nxt;
  logic          o_has_r, o_has_nxt;
  logic          o_last_r, o_last_nxt;

  logic          in_ready;
  logic          in_acc;
  logic [7:0]    b;
  logic [7:0]    crc_step;
  logic [CW-1:0] cnt_inc;
  logic          out_free;
  logic          rd_more;
  logic          rd_load;
  logic          rd_issue;
  logic          empty_load;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign b        = in_ch.rx_byte;
  assign in_acc   = in_ch.valid && in_ready;
  assign crc_step = sfdc_pkg::crc8_feed(crc_r, b, cfg_r.crc_poly, cfg_r.crc_lsb_first);
  assign cnt_inc  = cnt_r + CW'(1);
  assign out_free = !out_valid_r || out_ch.ready;
  assign rd_more  = rd_idx_r < len_r;

  // control outputs
  always_comb begin
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    rd_load    = 1'b0;
    rd_issue   = 1'b0;
    empty_load = 1'b0;
    ram_waddr  = cnt_r[AW-1:0];
    ram_raddr  = rd_idx_r[AW-1:0];
    case (phase_r)
      sfdc_pkg::PH_EMIT: begin
        rd_load  = rd_pend_r && out_free;
        rd_issue = rd_more && (!rd_pend_r || rd_load);
        ram_re   = rd_issue;
      end
      sfdc_pkg::PH_TAIL: begin
        in_ready   = out_free;
        empty_load = in_acc && (b == cfg_r.tail_byte) && (len_r == '0);
      end
      sfdc_pkg::PH_DATA: begin
        in_ready = 1'b1;
        ram_we   = in_acc;
      end
      default: begin
        in_ready = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      sfdc_pkg::PH_HEAD: begin
        if (in_acc && b == cfg_r.head_byte) begin
          phase_nxt = sfdc_pkg::PH_LENGTH;
        end
      end
      sfdc_pkg::PH_LENGTH: begin
        if (in_acc) begin
          phase_nxt = (b > 8'(MAX_PAYLOAD)) ? sfdc_pkg::PH_HEAD : sfdc_pkg::PH_SENSOR;
        end
      end
      sfdc_pkg::PH_SENSOR: begin
        if (in_acc) begin
          phase_nxt = (len_r == '0) ? sfdc_pkg::PH_CRC : sfdc_pkg::PH_DATA;
        end
      end
      sfdc_pkg::PH_DATA: begin
        if (in_acc && cnt_inc >= len_r) begin
          phase_nxt = sfdc_pkg::PH_CRC;
        end
      end
      sfdc_pkg::PH_CRC: begin
        if (in_acc) begin
          phase_nxt = (crc_r == b) ? sfdc_pkg::PH_TAIL : sfdc_pkg::PH_HEAD;
        end
      end
      sfdc_pkg::PH_TAIL: begin
        if (in_acc) begin
          phase_nxt = (b == cfg_r.tail_byte && len_r != '0) ? sfdc_pkg::PH_EMIT
                                                              : sfdc_pkg::PH_HEAD;
        end
      end
      sfdc_pkg::PH_EMIT: begin
        if (!rd_more && rd_load) begin
          phase_nxt = sfdc_pkg::PH_HEAD;
        end
      end
      default: begin
        phase_nxt = sfdc_pkg::PH_HEAD;
      end
    endcase
  end

  // datapath
  always_comb begin
    cfg_nxt       = cfg_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    sensor_nxt    = sensor_r;
    crc_nxt       = crc_r;
    rd_idx_nxt    = rd_idx_r;
    rd_pend_nxt   = rd_pend_r;
    pend_addr_nxt = pend_addr_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    o_sensor_nxt  = o_sensor_r;
    o_len_nxt     = o_len_r;
    o_pos_nxt     = o_pos_r;
    o_val_nxt     = o_val_r;
    o_has_nxt     = o_has_r;
    o_last_nxt    = o_last_r;

    if (cfg_we) begin
      case (sfdc_pkg::cfg_reg_t'(cfg_index))
        sfdc_pkg::REG_HEAD_BYTE: cfg_nxt.head_byte     = cfg_wdata;
        sfdc_pkg::REG_TAIL_BYTE: cfg_nxt.tail_byte     = cfg_wdata;
        sfdc_pkg::REG_CRC_POLY:  cfg_nxt.crc_poly      = cfg_wdata;
        sfdc_pkg::REG_CRC_START: cfg_nxt.crc_start     = cfg_wdata;
        sfdc_pkg::REG_CRC_LSB:   cfg_nxt.crc_lsb_first = cfg_wdata[0];
        default: begin
        end
      endcase
    end

    case (phase_r)
      sfdc_pkg::PH_HEAD: begin
        if (in_acc && b == cfg_r.head_byte) begin
          cnt_nxt = '0;
          crc_nxt = cfg_r.crc_start;
        end
      end
      sfdc_pkg::PH_LENGTH: begin
        if (in_acc && b <= 8'(MAX_PAYLOAD)) begin
          len_nxt = b[CW-1:0];
          crc_nxt = crc_step;
        end
      end
      sfdc_pkg::PH_SENSOR: begin
        if (in_acc) begin
          sensor_nxt = b;
          crc_nxt    = crc_step;
          cnt_nxt    = '0;
        end
      end
      sfdc_pkg::PH_DATA: begin
        if (in_acc) begin
          crc_nxt = crc_step;
          cnt_nxt = cnt_inc;
        end
      end
      sfdc_pkg::PH_TAIL: begin
        rd_idx_nxt  = '0;
        rd_pend_nxt = 1'b0;
      end
      sfdc_pkg::PH_EMIT: begin
        if (rd_issue) begin
          rd_idx_nxt    = rd_idx_r + CW'(1);
          pend_addr_nxt = rd_idx_r[AW-1:0];
        end
        rd_pend_nxt = rd_issue || (rd_pend_r && !rd_load);
      end
      default: begin
      end
    endcase

    if (empty_load) begin
      out_valid_nxt = 1'b1;
      o_sensor_nxt  = sensor_r;
      o_len_nxt     = '0;
      o_pos_nxt     = '0;
      o_val_nxt     = '0;
      o_has_nxt     = 1'b0;
      o_last_nxt    = 1'b1;
    end else if (rd_load) begin
      out_valid_nxt = 1'b1;
      o_sensor_nxt  = sensor_r;
      o_len_nxt     = 6'(len_r);
      o_pos_nxt     = 6'(pend_addr_r);
      o_val_nxt     = ram_rdata;
      o_has_nxt     = 1'b1;
      o_last_nxt    = (CW'(pend_addr_r) + CW'(1)) == len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= sfdc_pkg::PH_HEAD;
      cfg_r         <= '{head_byte:     sfdc_pkg::HEAD_BYTE_RST,
                         tail_byte:     sfdc_pkg::TAIL_BYTE_RST,
                         crc_poly:      sfdc_pkg::CRC_POLY_RST,
                         crc_start:     sfdc_pkg::CRC_START_RST,
                         crc_lsb_first: sfdc_pkg::CRC_LSB_RST};
      cnt_r         <= '0;
      len_r         <= '0;
      sensor_r      <= '0;
      crc_r         <= sfdc_pkg::CRC_START_RST;
      rd_idx_r      <= '0;
      rd_pend_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      cfg_r         <= cfg_nxt;
      cnt_r         <= cnt_nxt;
      len_r         <= len_nxt;
      sensor_r      <= sensor_nxt;
      crc_r         <= crc_nxt;
      rd_idx_r      <= rd_idx_nxt;
      rd_pend_r     <= rd_pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    o_sensor_r  <= o_sensor_nxt;
    o_len_r     <= o_len_nxt;
    o_pos_r     <= o_pos_nxt;
    o_val_r     <= o_val_nxt;
    o_has_r     <= o_has_nxt;
    o_last_r    <= o_last_nxt;
  end

  sfdc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (b),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.frame_sensor  = o_sensor_r;
  assign out_ch.frame_length  = o_len_r;
  assign out_ch.byte_position = o_pos_r;
  assign out_ch.payload_value = o_val_r;
  assign out_ch.has_payload   = o_has_r;
  assign out_ch.last_of_frame = o_last_r;

endmodule

// ===== tb/sensor_frame_deframer_crc8_core_tb.sv =====
// testbench for sensor_frame_deframer_crc8_core: byte frames with random gaps and stalls,
// results checked against a frame tracker with its own crc-8
// depends on sfdc_pkg, sfdc_in_if, sfdc_out_if and the core
`timescale 1ns / 100ps

module sensor_frame_deframer_crc8_core_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int IDX_W = sfdc_pkg::CFG_IDX_W;
  localparam int DATA_W = sfdc_pkg::CFG_DATA_W;
  localparam int FIRST_SPARE_REG = int'(sfdc_pkg::REG_CRC_LSB) + 1;
  localparam int LAST_SPARE_REG = (1 << IDX_W) - 1;

  typedef logic [7:0] byte_q_t[$];

  typedef enum {
    SHAPE_GOOD,
    SHAPE_BAD_CRC,
    SHAPE_BAD_TAIL,
    SHAPE_TAIL_IS_HEAD,
    SHAPE_CUT,
    SHAPE_LONG,
    SHAPE_NOISE
  } frame_shape_t;

  typedef struct packed {
    logic [7:0] sensor;
    logic [5:0] length;
    logic [5:0] position;
    logic [7:0] value;
    logic       has_payload;
    logic       last;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_wdata;

  sfdc_in_if in_ch ();
  sfdc_out_if out_ch ();

  sensor_frame_deframer_crc8_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  sfdc_pkg::cfg_t shadow_cfg;
  frame_result_t expected_results[$];
  int error_count = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;

  // frame tracker state
  sfdc_pkg::phase_t trk_phase;
  int trk_count;
  logic [7:0] trk_len;
  logic [7:0] trk_sensor;
  logic [7:0] trk_crc;
  logic [7:0] trk_store [sfdc_pkg::MAX_PAYLOAD];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] acc;
    logic [7:0] gen;
    acc = crc ^ data;
    gen = shadow_cfg.crc_poly;
    if (shadow_cfg.crc_lsb_first) begin
      for (int k = 0; k < 8; k++) gen[k] = shadow_cfg.crc_poly[7 - k];
      repeat (8) acc = (acc >> 1) ^ (acc[0] ? gen : 8'h00);
    end else begin
      repeat (8) acc = (acc << 1) ^ (acc[7] ? gen : 8'h00);
    end
    return acc;
  endfunction

  task automatic track_byte(input logic [7:0] b);
    frame_result_t r;
    case (trk_phase)
      sfdc_pkg::PH_HEAD: begin
        if (b == shadow_cfg.head_byte) begin
          trk_count = 0;
          trk_crc = shadow_cfg.crc_start;
          trk_phase = sfdc_pkg::PH_LENGTH;
        end
      end
      sfdc_pkg::PH_LENGTH: begin
        if (b > sfdc_pkg::MAX_PAYLOAD) begin
          trk_phase = sfdc_pkg::PH_HEAD;
        end else begin
          trk_len = b;
          trk_crc = crc8_next(trk_crc, b);
          trk_phase = sfdc_pkg::PH_SENSOR;
        end
      end
      sfdc_pkg::PH_SENSOR: begin
        trk_sensor = b;
        trk_crc = crc8_next(trk_crc, b);
        trk_count = 0;
        trk_phase = (trk_len == 0) ? sfdc_pkg::PH_CRC : sfdc_pkg::PH_DATA;
      end
      sfdc_pkg::PH_DATA: begin
        if (trk_count < sfdc_pkg::MAX_PAYLOAD) trk_store[trk_count] = b;
        trk_crc = crc8_next(trk_crc, b);
        trk_count++;
        if (trk_count >= trk_len) trk_phase = sfdc_pkg::PH_CRC;
      end
      sfdc_pkg::PH_CRC: begin
        trk_phase = (trk_crc == b) ? sfdc_pkg::PH_TAIL : sfdc_pkg::PH_HEAD;
      end
      sfdc_pkg::PH_TAIL: begin
        if (b == shadow_cfg.tail_byte) begin
          if (trk_len == 0) begin
            r = '{sensor: trk_sensor, length: 6'd0, position: 6'd0, value: 8'h00,
                  has_payload: 1'b0, last: 1'b1};
            expected_results.push_back(r);
          end else begin
            for (int k = 0; k < trk_len; k++) begin
              r = '{sensor: trk_sensor, length: trk_len[5:0], position: 6'(k),
                    value: trk_store[k], has_payload: 1'b1, last: (k + 1 == trk_len)};
              expected_results.push_back(r);
            end
          end
        end
        trk_phase = sfdc_pkg::PH_HEAD;
      end
      default: trk_phase = sfdc_pkg::PH_HEAD;
    endcase
  endtask

  task automatic report_error(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_error($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic check_result();
    frame_result_t want;
    if (expected_results.size() == 0) begin
      report_error($sformatf("unexpected transaction sensor %0h position %0d",
                             out_ch.frame_sensor, out_ch.byte_position));
    end else begin
      want = expected_results.pop_front();
      check_field("frame_sensor", out_ch.frame_sensor, want.sensor);
      check_field("frame_length", 8'(out_ch.frame_length), 8'(want.length));
      check_field("byte_position", 8'(out_ch.byte_position), 8'(want.position));
      check_field("payload_value", out_ch.payload_value, want.value);
      check_field("has_payload", 8'(out_ch.has_payload), 8'(want.has_payload));
      check_field("last_of_frame", 8'(out_ch.last_of_frame), 8'(want.last));
    end
  endtask

  // tracking and checking on accepted transactions
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) track_byte(in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) check_result();
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] value);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      in_ch.rx_byte <= 8'($urandom);
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drive_frame(input frame_shape_t shape, input logic [7:0] sensor,
                             input byte_q_t payload);
    logic [7:0] crc;
    logic [7:0] closing;
    int cut;
    send_byte(shadow_cfg.head_byte);
    if (shape == SHAPE_LONG) begin
      send_byte(8'($urandom_range(sfdc_pkg::MAX_PAYLOAD + 1, 255)));
      return;
    end
    crc = crc8_next(shadow_cfg.crc_start, 8'(payload.size()));
    send_byte(8'(payload.size()));
    crc = crc8_next(crc, sensor);
    send_byte(sensor);
    cut = (shape == SHAPE_CUT) ? $urandom_range(0, payload.size()) : payload.size();
    for (int i = 0; i < cut; i++) begin
      crc = crc8_next(crc, payload[i]);
      send_byte(payload[i]);
    end
    if (shape == SHAPE_CUT) return;
    if (shape == SHAPE_BAD_CRC) crc ^= 8'($urandom_range(1, 255));
    send_byte(crc);
    case (shape)
      SHAPE_BAD_TAIL: closing = shadow_cfg.tail_byte ^ 8'($urandom_range(1, 255));
      SHAPE_TAIL_IS_HEAD: begin
        closing = (shadow_cfg.head_byte != shadow_cfg.tail_byte) ?
                  shadow_cfg.head_byte : shadow_cfg.tail_byte ^ 8'h01;
      end
      default: closing = shadow_cfg.tail_byte;
    endcase
    send_byte(closing);
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 6);
    if (r < 95) return $urandom_range(7, 24);
    if (r < 98) return $urandom_range(25, sfdc_pkg::MAX_PAYLOAD - 1);
    return sfdc_pkg::MAX_PAYLOAD;
  endfunction

  task automatic send_random_frame();
    byte_q_t payload;
    frame_shape_t shape;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 64) shape = SHAPE_GOOD;
    else if (pick < 70) shape = SHAPE_BAD_CRC;
    else if (pick < 75) shape = SHAPE_BAD_TAIL;
    else if (pick < 79) shape = SHAPE_TAIL_IS_HEAD;
    else if (pick < 84) shape = SHAPE_CUT;
    else if (pick < 89) shape = SHAPE_LONG;
    else shape = SHAPE_NOISE;
    if (shape == SHAPE_NOISE) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      return;
    end
    repeat (pick_length()) payload.push_back(8'($urandom));
    drive_frame(shape, 8'($urandom), payload);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (sfdc_pkg::MAX_PAYLOAD + 4) @(posedge clk);
  endtask

  task automatic set_config(input sfdc_pkg::cfg_t c);
    cfg_we <= 1'b1;
    cfg_index <= sfdc_pkg::REG_HEAD_BYTE;
    cfg_wdata <= c.head_byte;
    @(posedge clk);
    cfg_index <= sfdc_pkg::REG_TAIL_BYTE;
    cfg_wdata <= c.tail_byte;
    @(posedge clk);
    cfg_index <= sfdc_pkg::REG_CRC_POLY;
    cfg_wdata <= c.crc_poly;
    @(posedge clk);
    cfg_index <= sfdc_pkg::REG_CRC_START;
    cfg_wdata <= c.crc_start;
    @(posedge clk);
    cfg_index <= sfdc_pkg::REG_CRC_LSB;
    cfg_wdata <= {7'($urandom), c.crc_lsb_first};
    @(posedge clk);
    // spare index, must be ignored
    cfg_index <= IDX_W'($urandom_range(FIRST_SPARE_REG, LAST_SPARE_REG));
    cfg_wdata <= DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_cfg = c;
  endtask

  function automatic sfdc_pkg::cfg_t random_cfg();
    sfdc_pkg::cfg_t c;
    c.head_byte = 8'($urandom);
    c.tail_byte = 8'($urandom);
    c.crc_poly = 8'($urandom);
    c.crc_start = 8'($urandom);
    c.crc_lsb_first = 1'($urandom);
    return c;
  endfunction

  task automatic test_directed_frames();
    byte_q_t payload;
    drive_frame(SHAPE_GOOD, 8'h00, payload);
    drive_frame(SHAPE_BAD_CRC, 8'($urandom), payload);
    send_byte(shadow_cfg.head_byte);
    send_byte(8'(sfdc_pkg::MAX_PAYLOAD + 1));
    drive_frame(SHAPE_TAIL_IS_HEAD, 8'($urandom), payload);
    // head value inside the payload, plus byte extremes
    payload = {shadow_cfg.head_byte, 8'h00, 8'hFF};
    drive_frame(SHAPE_GOOD, 8'hFF, payload);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    sfdc_pkg::cfg_t settings[3];
    int stop_at;
    settings[0] = '{head_byte: 8'h00, tail_byte: 8'h00, crc_poly: 8'h00, crc_start: 8'h00,
                    crc_lsb_first: 1'b0};
    settings[1] = '{head_byte: 8'hFF, tail_byte: 8'hFF, crc_poly: 8'hFF, crc_start: 8'hFF,
                    crc_lsb_first: 1'b1};
    settings[2] = '{head_byte: sfdc_pkg::HEAD_BYTE_RST, tail_byte: sfdc_pkg::TAIL_BYTE_RST,
                    crc_poly: sfdc_pkg::CRC_POLY_RST, crc_start: 8'hFF,
                    crc_lsb_first: 1'b1};
    foreach (settings[i]) begin
      set_config(settings[i]);
      stop_at = items_sent + 30;
      while (items_sent < stop_at) send_random_frame();
      wait_idle();
    end
  endtask

  task automatic test_random_frames();
    byte_q_t payload;
    int next_change;
    set_config(random_cfg());
    repeat (sfdc_pkg::MAX_PAYLOAD) payload.push_back(8'($urandom));
    drive_frame(SHAPE_GOOD, 8'($urandom), payload);
    next_change = items_sent + 70;
    while (items_sent < 380) begin
      if (items_sent >= next_change) begin
        wait_idle();
        set_config(random_cfg());
        next_change = items_sent + 70;
      end
      send_random_frame();
    end
    wait_idle();
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    set_config(random_cfg());
    while (items_sent < 460) send_random_frame();
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready = 1'b1;
    shadow_cfg = '{head_byte: sfdc_pkg::HEAD_BYTE_RST, tail_byte: sfdc_pkg::TAIL_BYTE_RST,
                   crc_poly: sfdc_pkg::CRC_POLY_RST, crc_start: sfdc_pkg::CRC_START_RST,
                   crc_lsb_first: sfdc_pkg::CRC_LSB_RST};
    trk_phase = sfdc_pkg::PH_HEAD;
    trk_count = 0;
    trk_len = 8'h00;
    trk_sensor = 8'h00;
    trk_crc = sfdc_pkg::CRC_START_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_register_extremes();
    test_random_frames();
    test_steady_stream();

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sfdc_pkg.sv
rtl/sfdc_in_if.sv
rtl/sfdc_out_if.sv
rtl/sfdc_ram.sv
rtl/sensor_frame_deframer_crc8_core.sv
tb/sensor_frame_deframer_crc8_core_tb.sv
